@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every sampled edge
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// cond must never be seen high
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

@@ rtl/core/tpr_pkg.sv @@
// Shared types and constants of the timestamped peak ring.
// No dependencies.
package tpr_pkg;

	localparam int LEVEL_W          = 16;
	localparam int STAMP_W          = 32;
	localparam int NUM_LEVEL_FIELDS = 8;

	// stamp held by slot 0 until it is first written
	localparam logic signed [STAMP_W-1:0] STAMP_AT_RESET = -32'sd1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_NEWEST = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_SCAN   = 4'b1000
	} state_t;

endpackage

@@ rtl/core/tpr_store.sv @@
// Ring storage: stamp memory and level-row memory, one write and one read port each.
// Slot 0 reads as its reset contents until first written. Depends on tpr_pkg.
module tpr_store import tpr_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int CH    = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic signed [STAMP_W-1:0]  wr_stamp,
	input  logic [CH*LEVEL_W-1:0]      wr_levels,
	input  logic [AW-1:0]              rd_addr,
	output logic signed [STAMP_W-1:0]  rd_stamp,
	output logic [CH*LEVEL_W-1:0]      rd_levels
);

	logic signed [STAMP_W-1:0] stamp_mem [DEPTH];
	logic [CH*LEVEL_W-1:0]     level_mem [DEPTH];

	logic signed [STAMP_W-1:0] stamp_rd_q;
	logic [CH*LEVEL_W-1:0]     level_rd_q;
	logic                      slot0_wr_q;
	logic                      rd_zero_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[wr_addr] <= wr_stamp;
			level_mem[wr_addr] <= wr_levels;
		end
		stamp_rd_q <= stamp_mem[rd_addr];
		level_rd_q <= level_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_wr_q <= 1'b0;
			rd_zero_q  <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0)
				slot0_wr_q <= 1'b1;
			rd_zero_q <= (rd_addr == '0) && !slot0_wr_q;
		end
	end

	assign rd_stamp  = rd_zero_q ? STAMP_AT_RESET : stamp_rd_q;
	assign rd_levels = rd_zero_q ? '0 : level_rd_q;

endmodule

@@ rtl/core/timestamped_peak_ring.sv @@
// Timestamped peak ring: top level with the query sequencer and per-channel max lanes.
// Depends on tpr_pkg and tpr_store.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------
//  command   | start / busy        | op, stamp, drop_old, level_0..level_7
//  result    | done (1-cycle)      | peak_0..peak_7
//
// An add is written without raising busy; busy stays low.
// A query walks W slots comparing stamps, then scans S level rows, one memory read per cycle
// on the single read port; a negative stamp first takes the newest stamp in the ring as bound.
// done pulses in the cycle after the scan ends; the receiver cannot stall.
// After reset the ring holds slot 0 only (stamp -1, levels zero); no clearing pass.
module timestamped_peak_ring import tpr_pkg::*; #(
	parameter int RING_DEPTH = 256,
	parameter int CHANNELS   = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      op,
	input  logic signed [STAMP_W-1:0] stamp,
	input  logic                      drop_old,
	input  logic [LEVEL_W-1:0]        level_0,
	input  logic [LEVEL_W-1:0]        level_1,
	input  logic [LEVEL_W-1:0]        level_2,
	input  logic [LEVEL_W-1:0]        level_3,
	input  logic [LEVEL_W-1:0]        level_4,
	input  logic [LEVEL_W-1:0]        level_5,
	input  logic [LEVEL_W-1:0]        level_6,
	input  logic [LEVEL_W-1:0]        level_7,
	output logic                      done,
	output logic [LEVEL_W-1:0]        peak_0,
	output logic [LEVEL_W-1:0]        peak_1,
	output logic [LEVEL_W-1:0]        peak_2,
	output logic [LEVEL_W-1:0]        peak_3,
	output logic [LEVEL_W-1:0]        peak_4,
	output logic [LEVEL_W-1:0]        peak_5,
	output logic [LEVEL_W-1:0]        peak_6,
	output logic [LEVEL_W-1:0]        peak_7
);

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	state_t                    state_q;
	logic [AW-1:0]             newest_q;
	logic [AW-1:0]             oldest_q;
	logic                      done_q;
	logic signed [STAMP_W-1:0] t_q;
	logic                      drop_q;
	logic [AW-1:0]             walk_q;
	logic [AW-1:0]             mark_q;
	logic [AW-1:0]             idx_q;
	logic [LEVEL_W-1:0]        peak_q   [CHANNELS];
	logic [LEVEL_W-1:0]        peak_nxt [CHANNELS];

	logic                          accept;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [CHANNELS*LEVEL_W-1:0]   wr_levels;
	logic [AW-1:0]                 rd_addr;
	logic signed [STAMP_W-1:0]     rd_stamp;
	logic [CHANNELS*LEVEL_W-1:0]   rd_levels;
	logic                          walk_go;
	logic                          scan_end;
	logic [LEVEL_W-1:0]            lvl_all  [NUM_LEVEL_FIELDS];
	logic [LEVEL_W-1:0]            peak_all [NUM_LEVEL_FIELDS];

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign wr_en   = accept && !op;
	assign wr_addr = adv(newest_q);

	assign lvl_all[0] = level_0;
	assign lvl_all[1] = level_1;
	assign lvl_all[2] = level_2;
	assign lvl_all[3] = level_3;
	assign lvl_all[4] = level_4;
	assign lvl_all[5] = level_5;
	assign lvl_all[6] = level_6;
	assign lvl_all[7] = level_7;

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		assign wr_levels[g*LEVEL_W +: LEVEL_W] = lvl_all[g];
		// one max lane per channel, shared by every scanned row
		assign peak_nxt[g] = (rd_levels[g*LEVEL_W +: LEVEL_W] > peak_q[g]) ?
			rd_levels[g*LEVEL_W +: LEVEL_W] : peak_q[g];
	end

	for (genvar g = 0; g < NUM_LEVEL_FIELDS; g++) begin : g_out
		if (g < CHANNELS) begin : g_live
			assign peak_all[g] = peak_q[g];
		end else begin : g_zero
			assign peak_all[g] = '0;
		end
	end

	// rd_stamp belongs to walk_q in WALK, rd_levels to idx_q in SCAN
	assign walk_go  = (rd_stamp < t_q) && (walk_q != newest_q);
	assign scan_end = (idx_q == mark_q) || (adv(idx_q) == mark_q);

	// next read is issued speculatively; a read past the end is ignored
	always_comb begin
		case (state_q)
			ST_IDLE:   rd_addr = stamp[STAMP_W-1] ? newest_q : oldest_q;
			ST_NEWEST: rd_addr = oldest_q;
			ST_WALK:   rd_addr = walk_go ? adv(walk_q) : oldest_q;
			ST_SCAN:   rd_addr = adv(idx_q);
			default:   rd_addr = oldest_q;
		endcase
	end

	tpr_store #(
		.DEPTH (RING_DEPTH),
		.CH    (CHANNELS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_stamp  (stamp),
		.wr_levels (wr_levels),
		.rd_addr   (rd_addr),
		.rd_stamp  (rd_stamp),
		.rd_levels (rd_levels)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			newest_q <= '0;
			oldest_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && op) begin
						state_q <= stamp[STAMP_W-1] ? ST_NEWEST : ST_WALK;
					end else if (accept) begin
						newest_q <= wr_addr;
						if (wr_addr == oldest_q)
							oldest_q <= adv(oldest_q);
					end
				end
				ST_NEWEST: state_q <= ST_WALK;
				ST_WALK: begin
					if (!walk_go)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_end) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (drop_q)
							oldest_q <= mark_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && op) begin
					t_q    <= stamp;
					drop_q <= drop_old;
					walk_q <= oldest_q;
					mark_q <= oldest_q;
				end
			end
			ST_NEWEST: t_q <= rd_stamp;
			ST_WALK: begin
				if (walk_go) begin
					mark_q <= walk_q;
					walk_q <= adv(walk_q);
				end else begin
					idx_q <= oldest_q;
					for (int c = 0; c < CHANNELS; c++)
						peak_q[c] <= '0;
				end
			end
			ST_SCAN: begin
				idx_q <= adv(idx_q);
				for (int c = 0; c < CHANNELS; c++)
					peak_q[c] <= peak_nxt[c];
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign peak_0 = peak_all[0];
	assign peak_1 = peak_all[1];
	assign peak_2 = peak_all[2];
	assign peak_3 = peak_all[3];
	assign peak_4 = peak_all[4];
	assign peak_5 = peak_all[5];
	assign peak_6 = peak_all[6];
	assign peak_7 = peak_all[7];

endmodule

@@ rtl/core/tpr_checker.sv @@
// Port-level checker for the timestamped peak ring, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tpr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic op,
	input logic done
);

	// an add word does not raise busy or done
	`ASSERT_CLK(a_add_one_cycle, (start && !busy && !op) |=> (!busy && !done))
	// a query word holds the block busy
	`ASSERT_CLK(a_query_busy, (start && !busy && op) |=> busy)
	// a result only follows a query in flight
	`ASSERT_CLK(a_done_after_busy, done |-> $past(busy))
	`ASSERT_NEVER(a_done_twice, done && $past(done))

endmodule

bind timestamped_peak_ring tpr_checker u_tpr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.op     (op),
	.done   (done)
);
